@@ hdl/median_filter_2d_clamped_border_unit_assert.svh @@
// Assertion macros shared by the block's checker.
`ifndef MEDIAN_FILTER_2D_CLAMPED_BORDER_UNIT_ASSERT_SVH
`define MEDIAN_FILTER_2D_CLAMPED_BORDER_UNIT_ASSERT_SVH
// antecedent holds -> consequent holds in the next cycle
`define MF2D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
// antecedent holds -> consequent holds in the same cycle
`define MF2D_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// checked during reset as well
`define MF2D_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ hdl/mf2d_pkg.sv @@
// Package: types and constants of the 2-D median filter.
package mf2d_pkg;
   localparam int CfgIdxW = 2;
   localparam logic [CfgIdxW-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CfgIdxW-1:0] REG_RADIUS = 2'd2;
   localparam int CfgDataW = 13;
   localparam int WidthRegW = 11;
   localparam int HeightRegW = 13;
   localparam int RadiusRegW = 2;
   localparam logic [WidthRegW-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HeightRegW-1:0] HEIGHT_RESET = 13'd1024;
   localparam logic [RadiusRegW-1:0] RADIUS_RESET = 2'd1;
   localparam int PixW = 32;
   localparam int OutXW = 10;
   localparam int OutYW = 12;
   localparam int BitW = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_FLUSH,
      ST_BIT
   } state_type;
endpackage

@@ hdl/mf2d_if.sv @@
// Stream interfaces for the pixel request and result channels.
interface mf2d_req_if import mf2d_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            op;
   logic [PixW-1:0] pixel_in;
   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface mf2d_rsp_if import mf2d_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PixW-1:0]  pixel_out;
   logic [OutXW-1:0] out_x;
   logic [OutYW-1:0] out_y;
   logic             last_of_run;
   logic             last_of_frame;
   modport source (output valid, output pixel_out, output out_x, output out_y,
                   output last_of_run, output last_of_frame, input ready);
   modport sink   (input valid, input pixel_out, input out_x, input out_y,
                   input last_of_run, input last_of_frame, output ready);
endinterface

@@ hdl/median_filter_2d_clamped_border_unit.sv @@
// Top level: streaming 2-D median filter with clamped borders.
//
// req_chan carries input items: op 0 delivers the next pixel of the frame in
// raster order, op 1 drains one pending output. rsp_chan carries results:
// median, its column and row, last_of_run and last_of_frame.
// The csr port sets width, height and radius; such a write restarts the frame.
// One item is taken at a time. A pixel is written to the line store in the
// cycle it transfers. For each result the median is found by a bit-serial
// radix select that reads the (2R+1)^2 window from the single read port of
// the line store once for every bit of the 32-bit word. A pixel item makes
// up to R+1 results, a drain item at most one.
// Results sit in an output register; the next item is taken while the last
// result waits. A stalled receiver holds the block when a further result
// must be moved out.
// Synchronous reset clears positions and handshakes and restores the
// register defaults; the line store is not cleared, every entry read was
// written earlier in the same frame.
module median_filter_2d_clamped_border_unit import mf2d_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 3
) (
   input  logic                clock,
   input  logic                reset,
   mf2d_req_if.sink            req_chan,
   mf2d_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  logic [CfgIdxW-1:0]  csr_index,
   input  logic [CfgDataW-1:0] csr_write_data
);
   localparam int SLOTS = 2 * MAX_RADIUS + 1;
   localparam int WIN_MAX = SLOTS * SLOTS;
   localparam int DEPTH = SLOTS * MAX_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int WCW = ($clog2(MAX_WIDTH + 1) > WidthRegW) ?
                        $clog2(MAX_WIDTH + 1) : WidthRegW;
   localparam int HCW = ($clog2(MAX_HEIGHT + 1) > HeightRegW) ?
                        $clog2(MAX_HEIGHT + 1) : HeightRegW;
   localparam int RW = ($clog2(MAX_RADIUS + 1) > RadiusRegW) ?
                       $clog2(MAX_RADIUS + 1) : RadiusRegW;
   localparam int OW = RW + 2;
   localparam int SW = $clog2(SLOTS);
   localparam int KW = $clog2(WIN_MAX);
   localparam int CW = $clog2(WIN_MAX + 1);
   localparam int EW = $clog2(MAX_RADIUS + 2);

   state_type state_ff, state_in;
   logic [WidthRegW-1:0]  width_ff, width_in;
   logic [HeightRegW-1:0] height_ff, height_in;
   logic [RadiusRegW-1:0] radius_ff, radius_in;
   logic [XW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [YW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SW-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic          in_done_ff, in_done_in;
   logic [EW-1:0] emit_cnt_ff, emit_cnt_in;
   logic          pix_item_ff, pix_item_in;
   logic signed [OW-1:0] i_ff, i_in, j_ff, j_in;
   logic [BitW-1:0] bit_ff, bit_in;
   logic [PixW-1:0] prefix_ff, prefix_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [CW-1:0]   tally_ff, tally_in;
   logic            rdv_ff, rdv_in;
   logic            hold_v_ff, hold_v_in;
   logic [PixW-1:0] hold_pix_ff, hold_pix_in;
   logic [XW-1:0]   hold_x_ff, hold_x_in;
   logic [YW-1:0]   hold_y_ff, hold_y_in;
   logic            hold_lof_ff, hold_lof_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [PixW-1:0] rsp_pix_ff, rsp_pix_in;
   logic [XW-1:0]   rsp_x_ff, rsp_x_in;
   logic [YW-1:0]   rsp_y_ff, rsp_y_in;
   logic            rsp_lor_ff, rsp_lor_in;
   logic            rsp_lof_ff, rsp_lof_in;

   logic [WCW-1:0] eff_w, w_m1;
   logic [HCW-1:0] eff_h, h_m1;
   logic [RW-1:0]  eff_r;
   logic           req_xfer, out_free, nready, more, item_end;
   logic [WCW:0]   tx;
   logic [HCW:0]   ty;
   logic [EW:0]    limit;
   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [PixW-1:0] ram_rdata;
   logic signed [WCW+1:0] cs;
   logic signed [HCW+1:0] rs;
   logic [XW-1:0]  rd_col;
   logic [YW-1:0]  rd_row;
   logic signed [SW+2:0] slot_s;
   logic [SW-1:0]  rd_slot;
   logic [PixW:0]  low_mask;
   logic [PixW-1:0] hi_mask;
   logic           match;
   logic [PixW-1:0] prefix_set;
   logic           take_one;
   logic [KW-1:0]  k_init;

   always_comb begin
      eff_w = WCW'(width_ff);
      if (width_ff == '0) begin
         eff_w = WCW'(1);
      end else if (WCW'(width_ff) > WCW'(MAX_WIDTH)) begin
         eff_w = WCW'(MAX_WIDTH);
      end
      eff_h = HCW'(height_ff);
      if (height_ff == '0) begin
         eff_h = HCW'(1);
      end else if (HCW'(height_ff) > HCW'(MAX_HEIGHT)) begin
         eff_h = HCW'(MAX_HEIGHT);
      end
      eff_r = RW'(radius_ff);
      if (RW'(radius_ff) > RW'(MAX_RADIUS)) begin
         eff_r = RW'(MAX_RADIUS);
      end
   end
   assign w_m1 = eff_w - WCW'(1);
   assign h_m1 = eff_h - HCW'(1);

   // next pending output complete?
   always_comb begin
      tx = (WCW + 1)'(out_col_ff) + (WCW + 1)'(eff_r);
      if (tx > (WCW + 1)'(w_m1)) begin
         tx = (WCW + 1)'(w_m1);
      end
      ty = (HCW + 1)'(out_row_ff) + (HCW + 1)'(eff_r);
      if (ty > (HCW + 1)'(h_m1)) begin
         ty = (HCW + 1)'(h_m1);
      end
      if ((HCW + 1)'(out_row_ff) >= (HCW + 1)'(eff_h)) begin
         nready = 1'b0;
      end else if (in_done_ff) begin
         nready = 1'b1;
      end else begin
         nready = ((HCW + 1)'(in_row_ff) > ty) ||
                  (((HCW + 1)'(in_row_ff) == ty) && ((WCW + 1)'(in_col_ff) > tx));
      end
   end

   assign limit = pix_item_ff ? ((EW + 1)'(eff_r) + (EW + 1)'(1)) : (EW + 1)'(1);
   assign more = nready && ((EW + 1)'(emit_cnt_ff) < limit);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign k_init = KW'(KW'({eff_r, 1'b0}) * (KW'(eff_r) + KW'(1)));

   // window read address
   always_comb begin
      cs = $signed({2'b00, WCW'(out_col_ff)}) + (WCW + 2)'(i_ff);
      if (cs < 0) begin
         rd_col = '0;
      end else if (cs > $signed({2'b00, w_m1})) begin
         rd_col = XW'(w_m1);
      end else begin
         rd_col = XW'(cs);
      end
      rs = $signed({2'b00, HCW'(out_row_ff)}) + (HCW + 2)'(j_ff);
      if (rs < 0) begin
         rd_row = '0;
      end else if (rs > $signed({2'b00, h_m1})) begin
         rd_row = YW'(h_m1);
      end else begin
         rd_row = YW'(rs);
      end
      slot_s = $signed({3'b000, out_slot_ff}) +
               (SW + 3)'($signed({1'b0, rd_row}) - $signed({1'b0, out_row_ff}));
      if (slot_s < 0) begin
         slot_s = slot_s + (SW + 3)'(SLOTS);
      end else if (slot_s >= (SW + 3)'(SLOTS)) begin
         slot_s = slot_s - (SW + 3)'(SLOTS);
      end
      rd_slot = SW'(slot_s);
      ram_raddr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col);
   end

   assign ram_we = (state_ff == ST_IDLE) && req_xfer && !req_chan.op && !in_done_ff;
   assign ram_waddr = AW'(in_slot_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);

   mf2d_ram #(.WIDTH(PixW), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_chan.pixel_in),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // radix select: count window words matching the prefix with this bit clear
   assign low_mask = ((PixW + 1)'(2) << bit_ff) - (PixW + 1)'(1);
   assign hi_mask = ~PixW'(low_mask);
   assign match = (((ram_rdata ^ prefix_ff) & hi_mask) == '0) && !ram_rdata[bit_ff];
   assign take_one = !((CW)'(k_ff) < tally_ff);
   assign prefix_set = prefix_ff | (PixW'(1) << bit_ff);
   assign item_end = (i_ff == OW'(eff_r)) && (j_ff == OW'(eff_r));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (hold_v_ff && !out_free) begin
               state_in = ST_CHECK;
            end else if (more) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (item_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_BIT;
         end
         ST_BIT: begin
            state_in = (bit_ff == '0) ? ST_CHECK : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      in_slot_in = in_slot_ff;
      in_done_in = in_done_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_slot_in = out_slot_ff;
      emit_cnt_in = emit_cnt_ff;
      pix_item_in = pix_item_ff;
      i_in = i_ff;
      j_in = j_ff;
      bit_in = bit_ff;
      prefix_in = prefix_ff;
      k_in = k_ff;
      tally_in = rdv_ff && match ? tally_ff + CW'(1) : tally_ff;
      rdv_in = 1'b0;
      hold_v_in = hold_v_ff;
      hold_pix_in = hold_pix_ff;
      hold_x_in = hold_x_ff;
      hold_y_in = hold_y_ff;
      hold_lof_in = hold_lof_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pix_in = rsp_pix_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_lor_in = rsp_lor_ff;
      rsp_lof_in = rsp_lof_ff;
      req_chan.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pix_item_in = !req_chan.op;
               // pixel after frame end is ignored: nothing left to emit
               emit_cnt_in = (!req_chan.op && in_done_ff) ? EW'(MAX_RADIUS + 1) : '0;
               if (!req_chan.op && !in_done_ff) begin
                  if ((WCW)'(in_col_ff) >= w_m1) begin
                     in_col_in = '0;
                     if ((HCW)'(in_row_ff) >= h_m1) begin
                        in_done_in = 1'b1;
                     end else begin
                        in_row_in = in_row_ff + YW'(1);
                        in_slot_in = (in_slot_ff == SW'(SLOTS - 1)) ? '0 :
                                     in_slot_ff + SW'(1);
                     end
                  end else begin
                     in_col_in = in_col_ff + XW'(1);
                  end
               end
            end
         end
         ST_CHECK: begin
            if (!(hold_v_ff && !out_free)) begin
               if (hold_v_ff) begin
                  hold_v_in = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_pix_in = hold_pix_ff;
                  rsp_x_in = hold_x_ff;
                  rsp_y_in = hold_y_ff;
                  rsp_lof_in = hold_lof_ff;
                  rsp_lor_in = !more;
               end
               if (more) begin
                  i_in = -OW'(eff_r);
                  j_in = -OW'(eff_r);
                  bit_in = BitW'(PixW - 1);
                  prefix_in = '0;
                  k_in = k_init;
                  tally_in = '0;
               end
            end
         end
         ST_READ: begin
            rdv_in = 1'b1;
            if (i_ff == OW'(eff_r)) begin
               i_in = -OW'(eff_r);
               j_in = j_ff + OW'(1);
            end else begin
               i_in = i_ff + OW'(1);
            end
         end
         ST_FLUSH: begin
         end
         ST_BIT: begin
            if (take_one) begin
               prefix_in = prefix_set;
               k_in = KW'(CW'(k_ff) - tally_ff);
            end
            tally_in = '0;
            i_in = -OW'(eff_r);
            j_in = -OW'(eff_r);
            if (bit_ff == '0) begin
               hold_v_in = 1'b1;
               hold_pix_in = take_one ? prefix_set : prefix_ff;
               hold_x_in = out_col_ff;
               hold_y_in = out_row_ff;
               emit_cnt_in = emit_cnt_ff + EW'(1);
               hold_lof_in = ((WCW)'(out_col_ff) == w_m1) && ((HCW)'(out_row_ff) == h_m1);
               if (((WCW)'(out_col_ff) == w_m1) && ((HCW)'(out_row_ff) == h_m1)) begin
                  in_col_in = '0;
                  in_row_in = '0;
                  in_slot_in = '0;
                  in_done_in = 1'b0;
                  out_col_in = '0;
                  out_row_in = '0;
                  out_slot_in = '0;
               end else if ((WCW)'(out_col_ff) == w_m1) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + YW'(1);
                  out_slot_in = (out_slot_ff == SW'(SLOTS - 1)) ? '0 :
                                out_slot_ff + SW'(1);
               end else begin
                  out_col_in = out_col_ff + XW'(1);
               end
            end else begin
               bit_in = bit_ff - BitW'(1);
            end
         end
         default: begin
         end
      endcase

      if (csr_write_enable && (csr_index == REG_WIDTH || csr_index == REG_HEIGHT ||
                               csr_index == REG_RADIUS)) begin
         unique case (csr_index)
            REG_WIDTH:  width_in = WidthRegW'(csr_write_data);
            REG_HEIGHT: height_in = HeightRegW'(csr_write_data);
            default:    radius_in = RadiusRegW'(csr_write_data);
         endcase
         in_col_in = '0;
         in_row_in = '0;
         in_slot_in = '0;
         in_done_in = 1'b0;
         out_col_in = '0;
         out_row_in = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_slot_ff <= '0;
         in_done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_slot_ff <= '0;
         emit_cnt_ff <= '0;
         pix_item_ff <= 1'b0;
         rdv_ff <= 1'b0;
         hold_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         in_slot_ff <= in_slot_in;
         in_done_ff <= in_done_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_slot_ff <= out_slot_in;
         emit_cnt_ff <= emit_cnt_in;
         pix_item_ff <= pix_item_in;
         rdv_ff <= rdv_in;
         hold_v_ff <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      bit_ff <= bit_in;
      prefix_ff <= prefix_in;
      k_ff <= k_in;
      tally_ff <= tally_in;
      hold_pix_ff <= hold_pix_in;
      hold_x_ff <= hold_x_in;
      hold_y_ff <= hold_y_in;
      hold_lof_ff <= hold_lof_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_lor_ff <= rsp_lor_in;
      rsp_lof_ff <= rsp_lof_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pix_ff;
   assign rsp_chan.out_x = OutXW'(rsp_x_ff);
   assign rsp_chan.out_y = OutYW'(rsp_y_ff);
   assign rsp_chan.last_of_run = rsp_lor_ff;
   assign rsp_chan.last_of_frame = rsp_lof_ff;
endmodule

@@ hdl/mf2d_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module mf2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/mf2d_checker.sv @@
// Port-level checker for the median filter and its bind.
`include "median_filter_2d_clamped_border_unit_assert.svh"
module mf2d_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_of_run,
   input logic rsp_last_of_frame
);
   `MF2D_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `MF2D_ASSERT_RST(a_rsp_reset, reset, !rsp_valid)
   `MF2D_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready)
   `MF2D_ASSERT_NOW(a_frame_ends_run, rsp_valid && rsp_last_of_frame, rsp_last_of_run)
endmodule

bind median_filter_2d_clamped_border_unit mf2d_checker u_mf2d_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_last_of_run   (rsp_chan.last_of_run),
   .rsp_last_of_frame (rsp_chan.last_of_frame)
);

@@ bench/tb_median_filter_2d_clamped_border_unit.sv @@
// Testbench: clamped-border median filter, checked against a behavioral window predictor.
module tb_median_filter_2d_clamped_border_unit;
   import mf2d_pkg::*;

   localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
   localparam int LIM_W = 1024;
   localparam int LIM_H = 4096;
   localparam int LIM_R = 3;
   localparam int SLOTS = 2 * LIM_R + 1;
   localparam int CYCLE_LIMIT = 10000000;
   localparam bit OP_PIXEL = 1'b0;
   localparam bit OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [PixW-1:0]  pix;
      logic [OutXW-1:0] x;
      logic [OutYW-1:0] y;
      logic             lr;
      logic             lf;
   } median_type;

   typedef struct {
      bit                  cfg;
      logic [CfgIdxW-1:0]  idx;
      logic [CfgDataW-1:0] data;
      bit                  op;
      logic [PixW-1:0]     pix;
      bit                  typed;
      median_type          exp;
   } row_type;

   logic clock;
   logic reset;
   logic                csr_write_enable;
   logic [CfgIdxW-1:0]  csr_index;
   logic [CfgDataW-1:0] csr_write_data;

   mf2d_req_if req_bus ();
   mf2d_rsp_if rsp_bus ();

   median_filter_2d_clamped_border_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state
   logic [PixW-1:0] lstore [SLOTS][LIM_W];
   int unsigned w_reg, h_reg, r_reg;
   int unsigned in_col, in_row, out_col, out_row;
   bit in_done;
   median_type pending_medians[$];

   int errors;
   int cyc;
   int send_pct, stall_pct;

   function automatic int unsigned eff_w();
      return (w_reg < 1) ? 1 : ((w_reg > LIM_W) ? LIM_W : w_reg);
   endfunction
   function automatic int unsigned eff_h();
      return (h_reg < 1) ? 1 : ((h_reg > LIM_H) ? LIM_H : h_reg);
   endfunction
   function automatic int unsigned eff_r();
      return (r_reg > LIM_R) ? LIM_R : r_reg;
   endfunction

   function automatic void restart_frame();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 0;
   endfunction

   function automatic bit window_complete();
      int unsigned tx, ty;
      if (out_row >= eff_h()) return 0;
      if (in_done) return 1;
      tx = out_col + eff_r(); if (tx > eff_w() - 1) tx = eff_w() - 1;
      ty = out_row + eff_r(); if (ty > eff_h() - 1) ty = eff_h() - 1;
      return (in_row > ty) || (in_row == ty && in_col > tx);
   endfunction

   function automatic logic [PixW-1:0] window_median();
      logic [PixW-1:0] vals [SLOTS*SLOTS];
      logic [PixW-1:0] v;
      int n, k, rr, cc;
      int r;
      n = 0;
      r = eff_r();
      for (int j = -r; j <= r; j++) begin
         rr = int'(out_row) + j;
         if (rr < 0) rr = 0;
         if (rr > int'(eff_h()) - 1) rr = eff_h() - 1;
         for (int i = -r; i <= r; i++) begin
            cc = int'(out_col) + i;
            if (cc < 0) cc = 0;
            if (cc > int'(eff_w()) - 1) cc = eff_w() - 1;
            v = lstore[rr % SLOTS][cc];
            k = n;
            while (k > 0 && vals[k-1] > v) begin
               vals[k] = vals[k-1];
               k--;
            end
            vals[k] = v;
            n++;
         end
      end
      return vals[n/2];
   endfunction

   function automatic void emit_median();
      median_type m;
      bit fin;
      fin = (out_col == eff_w() - 1) && (out_row == eff_h() - 1);
      m.pix = window_median();
      m.x = out_col[OutXW-1:0];
      m.y = out_row[OutYW-1:0];
      m.lr = 0;
      m.lf = fin;
      pending_medians.push_back(m);
      if (fin) restart_frame();
      else if (out_col == eff_w() - 1) begin
         out_col = 0;
         out_row++;
      end else out_col++;
   endfunction

   function automatic int predict_filter(bit op, logic [PixW-1:0] pix);
      int cnt;
      cnt = 0;
      if (op == OP_PIXEL) begin
         if (in_done) return 0;
         lstore[in_row % SLOTS][in_col] = pix;
         if (in_col >= eff_w() - 1) begin
            in_col = 0;
            if (in_row >= eff_h() - 1) in_done = 1;
            else in_row++;
         end else in_col++;
         while (cnt < int'(eff_r()) + 1 && window_complete()) begin
            emit_median();
            cnt++;
         end
      end else if (window_complete()) begin
         emit_median();
         cnt = 1;
      end
      if (cnt > 0) pending_medians[$].lr = 1;
      return cnt;
   endfunction

   function automatic int item_latency();
      int s;
      s = 2 * eff_r() + 1;
      return (eff_r() + 1) * (32 * (s * s + 2) + 2) + 20;
   endfunction

   // one item over the request channel; prediction at the accepting edge
   task automatic send_item(bit op, logic [PixW-1:0] pix, bit typed, median_type exp);
      int base;
      while (send_pct > 0 && $urandom_range(99) < send_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (!req_bus.ready);
      base = pending_medians.size();
      void'(predict_filter(op, pix));
      if (typed) begin
         while (pending_medians.size() > base) void'(pending_medians.pop_back());
         pending_medians.push_back(exp);
      end
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      req_bus.valid <= 1'b0;
      while (pending_medians.size() > 0) @(negedge clock);
      repeat (item_latency()) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_WIDTH:  begin w_reg = 32'(data[WidthRegW-1:0]);  restart_frame(); end
         REG_HEIGHT: begin h_reg = 32'(data[HeightRegW-1:0]); restart_frame(); end
         REG_RADIUS: begin r_reg = 32'(data[RadiusRegW-1:0]); restart_frame(); end
         default: ;
      endcase
   endtask

   function automatic logic [PixW-1:0] rand_pixel();
      case ($urandom_range(3))
         0: return $urandom_range(3);
         1: return 32'hFFFF_FFFC | $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // random frame: mostly well-formed raster with a few drains and stray pixels
   task automatic random_frame();
      int unsigned w, h, r, npx;
      median_type none;
      none = '0;
      r = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
      w = (r == 3) ? $urandom_range(1, 3) : $urandom_range(1, 7);
      h = (r == 3) ? $urandom_range(1, 3) : $urandom_range(1, 5);
      if ($urandom_range(7) == 0) w = 0;
      write_reg(REG_WIDTH, CfgDataW'(w));
      write_reg(REG_HEIGHT, CfgDataW'(h));
      write_reg(REG_RADIUS, CfgDataW'(r));
      npx = eff_w() * eff_h();
      for (int i = 0; i < npx; i++) begin
         if ($urandom_range(9) == 0) send_item(OP_DRAIN, $urandom, 0, none);
         send_item(OP_PIXEL, rand_pixel(), 0, none);
      end
      if ($urandom_range(3) == 0) send_item(OP_PIXEL, $urandom, 0, none);
      while (in_done || window_complete()) send_item(OP_DRAIN, $urandom, 0, none);
      send_item(OP_DRAIN, $urandom, 0, none);
   endtask

   row_type dir_rows[$];

   function automatic row_type cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      row_type t;
      t = '{default: '0};
      t.cfg = 1; t.idx = idx; t.data = data;
      return t;
   endfunction
   function automatic row_type item_row(bit op, logic [PixW-1:0] pix);
      row_type t;
      t = '{default: '0};
      t.op = op; t.pix = pix;
      return t;
   endfunction
   function automatic row_type single_row(logic [PixW-1:0] pix);
      row_type t;
      t = item_row(OP_PIXEL, pix);
      t.typed = 1;
      t.exp = '{pix: pix, x: '0, y: '0, lr: 1'b1, lf: 1'b1};
      return t;
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      if (!reset) rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      median_type m;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected transfer pix=%h x=%0d y=%0d", $time,
                     rsp_bus.pixel_out, rsp_bus.out_x, rsp_bus.out_y);
            errors++;
         end else begin
            m = pending_medians.pop_front();
            if (rsp_bus.pixel_out !== m.pix || rsp_bus.out_x !== m.x || rsp_bus.out_y !== m.y
                || rsp_bus.last_of_run !== m.lr || rsp_bus.last_of_frame !== m.lf) begin
               $display("%0t: expected pix=%h x=%0d y=%0d lr=%b lf=%b", $time,
                        m.pix, m.x, m.y, m.lr, m.lf);
               $display("%0t: actual   pix=%h x=%0d y=%0d lr=%b lf=%b", $time,
                        rsp_bus.pixel_out, rsp_bus.out_x, rsp_bus.out_y,
                        rsp_bus.last_of_run, rsp_bus.last_of_frame);
               errors++;
            end
         end
      end
   end

   initial begin
      row_type t;
      errors = 0; cyc = 0; send_pct = 0; stall_pct = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0; req_bus.op = 1'b0; req_bus.pixel_in = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0; csr_index = '0; csr_write_data = '0;
      w_reg = 32'(WIDTH_RESET); h_reg = 32'(HEIGHT_RESET); r_reg = 32'(RADIUS_RESET);
      restart_frame();

      // single-pixel frames, empty drain, unused index, tiny frame with ignored pixel,
      // largest sizes cut short, clamped zero sizes
      dir_rows = '{cfg_row(REG_WIDTH, 1), cfg_row(REG_HEIGHT, 1), cfg_row(REG_RADIUS, 0),
                   single_row(32'hFFFF_FFFF), single_row(32'h0000_0000),
                   item_row(OP_DRAIN, 32'h0), cfg_row(REG_UNUSED, 13'h1FFF),
                   cfg_row(REG_WIDTH, 3), cfg_row(REG_HEIGHT, 2), cfg_row(REG_RADIUS, 1),
                   item_row(OP_PIXEL, 32'h8000_0000), item_row(OP_PIXEL, 32'h7FFF_FFFF),
                   item_row(OP_PIXEL, 32'h0000_0001), item_row(OP_PIXEL, 32'hFFFF_FFFE),
                   item_row(OP_PIXEL, 32'h8000_0001), item_row(OP_PIXEL, 32'h0000_0002),
                   item_row(OP_PIXEL, 32'h5555_AAAA), item_row(OP_DRAIN, 32'h0),
                   item_row(OP_DRAIN, 32'h0), item_row(OP_DRAIN, 32'h0),
                   cfg_row(REG_RADIUS, 3), cfg_row(REG_WIDTH, 2047), cfg_row(REG_HEIGHT, 8191),
                   item_row(OP_PIXEL, 32'hAAAA_5555), item_row(OP_PIXEL, 32'h1234_5678),
                   cfg_row(REG_WIDTH, 0), cfg_row(REG_HEIGHT, 0), cfg_row(REG_RADIUS, 2),
                   single_row(32'h1234_5678)};

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         t = dir_rows[i];
         if (t.cfg) write_reg(t.idx, t.data);
         else send_item(t.op, t.pix, t.typed, t.exp);
      end

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 50; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 50; end
            default: begin send_pct = 10; stall_pct = 10; end
         endcase
         repeat (2) random_frame();
      end

      req_bus.valid <= 1'b0;
      while (pending_medians.size() > 0) @(posedge clock);
      repeat (item_latency()) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
